// ===== sv/sector_cache_tag_table_core_assert.svh =====
// Assertion macros used by the sector cache tag table core.
`ifndef SECTOR_CACHE_TAG_TABLE_CORE_ASSERT_SVH
`define SECTOR_CACHE_TAG_TABLE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SCTT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SCTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sctt_pkg.sv =====
// Types, codes and constants of the sector cache tag table.
package sctt_pkg;

  localparam int unsigned DefEntries = 16;
  localparam int unsigned StampW     = 32;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CountW     = 5;

  typedef enum logic [2:0] {
    CMD_FIND    = 3'd0,
    CMD_OBTAIN  = 3'd1,
    CMD_REPLACE = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_LOWEST  = 3'd5,
    CMD_FLUSH   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_FOUND = 2'd0,
    OUT_TAKEN = 2'd1,
    OUT_NONE  = 2'd2,
    OUT_DONE  = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SLOT,
    ST_RANK,
    ST_RANK_END,
    ST_FINAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       track;
    logic [7:0]       sector;
    logic [SlotW-1:0] slot;
    logic             option_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic [SlotW-1:0]  result_slot;
    logic [7:0]        result_track;
    logic [7:0]        result_sector;
    logic              result_dirty;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  // One directory record apart from its recency rank.
  typedef struct packed {
    logic [7:0]        track;
    logic [7:0]        sector;
    logic [StampW-1:0] stamp;
  } tag_t;

endpackage

// ===== sv/sctt_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
interface sctt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sector_cache_tag_table_core.sv =====
// Sector cache tag table: a sequencer that scans the entry memory through one comparator.
// Command flow: find, lowest, replace and obtain scan all entries; allocating obtain and
// free add a rank pass; release and free read their slot first; flush, unknown codes and an
// invalid slot go straight to the result. One entry is read per cycle through the single port.
// One command at a time; the next is taken the cycle after its result is registered.
// Reset clears valid and dirty bits and both counters at once; the entry memory is not reset.
`include "sector_cache_tag_table_core_assert.svh"

module sector_cache_tag_table_core #(
  parameter int unsigned ENTRIES = sctt_pkg::DefEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sctt_chan_if.sink    req_i,
  sctt_chan_if.source  rsp_o
);
  localparam int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW      = $clog2(ENTRIES + 1);
  localparam int unsigned OutSlotW = sctt_pkg::SlotW;
  localparam int unsigned OutCntW  = sctt_pkg::CountW;
  localparam int unsigned SW      = (IW > OutSlotW) ? IW : OutSlotW;
  localparam int unsigned StW     = sctt_pkg::StampW;

  sctt_pkg::state_e state_q, state_d;

  logic [2:0]        cmd_q, cmd_d;
  logic [7:0]        trk_q, trk_d;
  logic [7:0]        sec_q, sec_d;
  logic [OutSlotW-1:0] slot_q, slot_d;
  logic              opt_q, opt_d;

  logic [IW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;
  logic [CW-1:0]      count_q, count_d;
  logic [StW-1:0]     stamp_q, stamp_d;

  logic              found_q, found_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  sctt_pkg::tag_t    best_tag_q, best_tag_d;
  logic [IW-1:0]     best_rank_q, best_rank_d;
  logic              free_found_q, free_found_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;

  sctt_pkg::rsp_t    res_q, res_d;
  sctt_pkg::rsp_t    out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              st_we;
  logic [IW-1:0]     st_waddr;
  sctt_pkg::tag_t    st_wtag;
  logic [IW-1:0]     st_wrank;
  logic              st_re;
  logic [IW-1:0]     st_raddr;
  sctt_pkg::tag_t    st_rtag;
  logic [IW-1:0]     st_rrank;

  logic              accept;
  logic              last_addr;
  logic [SW-1:0]     slot_w;
  logic [IW-1:0]     slot_idx;
  logic              slot_ok;
  logic              alloc;
  logic              better;
  logic              out_free;

  assign accept    = req_i.valid && req_i.ready;
  assign last_addr = cnt_q == IW'(ENTRIES - 1);
  assign slot_w    = SW'(slot_q);
  assign slot_idx  = slot_w[IW-1:0];
  assign slot_ok   = (32'(slot_q) < ENTRIES) && valid_q[slot_idx];
  assign alloc     = (cmd_q == sctt_pkg::CMD_OBTAIN) && !found_q && opt_q && free_found_q;
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign req_i.ready = state_q == sctt_pkg::ST_IDLE;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  sctt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wtag_i  (st_wtag),
    .wrank_i (st_wrank),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rtag_o  (st_rtag),
    .rrank_o (st_rrank)
  );

  sctt_cmp #(
    .RankW (IW)
  ) u_cmp (
    .mode_i       (cmd_q),
    .opt_i        (opt_q),
    .key_track_i  (trk_q),
    .key_sector_i (sec_q),
    .cand_valid_i (valid_q[pend_idx_q]),
    .cand_dirty_i (dirty_q[pend_idx_q]),
    .cand_tag_i   (st_rtag),
    .cand_rank_i  (st_rrank),
    .best_found_i (found_q),
    .best_tag_i   (best_tag_q),
    .best_rank_i  (best_rank_q),
    .better_o     (better)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sctt_pkg::ST_IDLE: begin
        if (accept) state_d = sctt_pkg::ST_DISPATCH;
      end
      sctt_pkg::ST_DISPATCH: begin
        unique case (cmd_q) inside
          sctt_pkg::CMD_FIND, sctt_pkg::CMD_OBTAIN, sctt_pkg::CMD_REPLACE,
          sctt_pkg::CMD_LOWEST: state_d = sctt_pkg::ST_SCAN;
          sctt_pkg::CMD_RELEASE, sctt_pkg::CMD_FREE: begin
            state_d = slot_ok ? sctt_pkg::ST_SLOT : sctt_pkg::ST_RESP;
          end
          default: state_d = sctt_pkg::ST_RESP;
        endcase
      end
      sctt_pkg::ST_SCAN: begin
        if (last_addr) state_d = sctt_pkg::ST_SCAN_END;
      end
      sctt_pkg::ST_SCAN_END: state_d = sctt_pkg::ST_DECIDE;
      sctt_pkg::ST_DECIDE:   state_d = alloc ? sctt_pkg::ST_RANK : sctt_pkg::ST_RESP;
      sctt_pkg::ST_SLOT: begin
        state_d = (cmd_q == sctt_pkg::CMD_FREE) ? sctt_pkg::ST_RANK : sctt_pkg::ST_RESP;
      end
      sctt_pkg::ST_RANK: begin
        if (last_addr) state_d = sctt_pkg::ST_RANK_END;
      end
      sctt_pkg::ST_RANK_END: state_d = sctt_pkg::ST_FINAL;
      sctt_pkg::ST_FINAL:    state_d = sctt_pkg::ST_RESP;
      sctt_pkg::ST_RESP: begin
        if (out_free) state_d = sctt_pkg::ST_IDLE;
      end
      default: state_d = sctt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_d        = cmd_q;
    trk_d        = trk_q;
    sec_d        = sec_q;
    slot_d       = slot_q;
    opt_d        = opt_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pend_idx_d   = cnt_q;
    valid_d      = valid_q;
    dirty_d      = dirty_q;
    count_d      = count_q;
    stamp_d      = stamp_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_tag_d   = best_tag_q;
    best_rank_d  = best_rank_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    st_we        = 1'b0;
    st_waddr     = pend_idx_q;
    st_wtag      = st_rtag;
    st_wrank     = st_rrank;
    st_re        = 1'b0;
    st_raddr     = cnt_q;

    // Read data of the entry issued last cycle is checked while scanning.
    if (pend_q && (state_q == sctt_pkg::ST_SCAN || state_q == sctt_pkg::ST_SCAN_END)) begin
      if (better) begin
        found_d     = 1'b1;
        best_idx_d  = pend_idx_q;
        best_tag_d  = st_rtag;
        best_rank_d = st_rrank;
      end
      if (!valid_q[pend_idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = pend_idx_q;
      end
    end

    // Rank pass: ages every valid entry on insert, or closes the gap left by a free.
    if (pend_q && (state_q == sctt_pkg::ST_RANK || state_q == sctt_pkg::ST_RANK_END)) begin
      if (cmd_q == sctt_pkg::CMD_OBTAIN) begin
        st_we    = valid_q[pend_idx_q];
        st_wrank = st_rrank + IW'(1);
      end else begin
        st_we    = valid_q[pend_idx_q] && (st_rrank > best_rank_q);
        st_wrank = st_rrank - IW'(1);
      end
    end

    unique case (state_q)
      sctt_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d  = req_i.data.command;
          trk_d  = req_i.data.track;
          sec_d  = req_i.data.sector;
          slot_d = req_i.data.slot;
          opt_d  = req_i.data.option_bit;
        end
      end
      sctt_pkg::ST_DISPATCH: begin
        res_d         = '0;
        res_d.outcome = sctt_pkg::OUT_NONE;
        cnt_d         = '0;
        found_d       = 1'b0;
        free_found_d  = 1'b0;
        unique case (cmd_q) inside
          sctt_pkg::CMD_FIND, sctt_pkg::CMD_OBTAIN, sctt_pkg::CMD_REPLACE,
          sctt_pkg::CMD_LOWEST: begin
          end
          sctt_pkg::CMD_RELEASE, sctt_pkg::CMD_FREE: begin
            st_re    = slot_ok;
            st_raddr = slot_idx;
          end
          sctt_pkg::CMD_FLUSH: begin
            valid_d       = '0;
            dirty_d       = '0;
            count_d       = '0;
            res_d.outcome = sctt_pkg::OUT_DONE;
          end
          default: begin
          end
        endcase
      end
      sctt_pkg::ST_SCAN, sctt_pkg::ST_RANK: begin
        st_re      = 1'b1;
        st_raddr   = cnt_q;
        pend_d     = 1'b1;
        pend_idx_d = cnt_q;
        cnt_d      = cnt_q + IW'(1);
      end
      sctt_pkg::ST_SCAN_END, sctt_pkg::ST_RANK_END: begin
        cnt_d = '0;
      end
      sctt_pkg::ST_DECIDE: begin
        res_d         = '0;
        res_d.outcome = sctt_pkg::OUT_NONE;
        if (cmd_q == sctt_pkg::CMD_REPLACE) begin
          if (found_q) begin
            st_we               = 1'b1;
            st_waddr            = best_idx_q;
            st_wtag             = '{track: trk_q, sector: sec_q, stamp: stamp_q};
            st_wrank            = best_rank_q;
            dirty_d[best_idx_q] = 1'b0;
            stamp_d             = stamp_q + StW'(1);
            res_d.outcome       = sctt_pkg::OUT_TAKEN;
            res_d.result_slot   = OutSlotW'(best_idx_q);
            res_d.result_track  = trk_q;
            res_d.result_sector = sec_q;
          end
        end else if (found_q) begin
          res_d.outcome       = sctt_pkg::OUT_FOUND;
          res_d.result_slot   = OutSlotW'(best_idx_q);
          res_d.result_track  = best_tag_q.track;
          res_d.result_sector = best_tag_q.sector;
          res_d.result_dirty  = dirty_q[best_idx_q];
        end
      end
      sctt_pkg::ST_SLOT: begin
        best_idx_d          = slot_idx;
        best_tag_d          = st_rtag;
        best_rank_d         = st_rrank;
        res_d               = '0;
        res_d.outcome       = sctt_pkg::OUT_DONE;
        res_d.result_slot   = OutSlotW'(slot_idx);
        res_d.result_track  = st_rtag.track;
        res_d.result_sector = st_rtag.sector;
        res_d.result_dirty  = dirty_q[slot_idx];
        cnt_d               = '0;
        if (cmd_q == sctt_pkg::CMD_FREE) begin
          valid_d[slot_idx] = 1'b0;
          count_d           = count_q - CW'(1);
        end else if (opt_q) begin
          dirty_d[slot_idx]  = 1'b1;
          res_d.result_dirty = 1'b1;
        end
      end
      sctt_pkg::ST_FINAL: begin
        if (cmd_q == sctt_pkg::CMD_OBTAIN) begin
          st_we               = 1'b1;
          st_waddr            = free_idx_q;
          st_wtag             = '{track: trk_q, sector: sec_q, stamp: stamp_q};
          st_wrank            = '0;
          valid_d[free_idx_q] = 1'b1;
          dirty_d[free_idx_q] = 1'b0;
          count_d             = count_q + CW'(1);
          stamp_d             = stamp_q + StW'(1);
          res_d               = '0;
          res_d.outcome       = sctt_pkg::OUT_TAKEN;
          res_d.result_slot   = OutSlotW'(free_idx_q);
          res_d.result_track  = trk_q;
          res_d.result_sector = sec_q;
        end
      end
      sctt_pkg::ST_RESP: begin
        if (out_free) begin
          out_d             = res_q;
          out_d.entry_count = OutCntW'(count_q);
          out_valid_d       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sctt_pkg::ST_IDLE;
      pend_q       <= 1'b0;
      valid_q      <= '0;
      dirty_q      <= '0;
      count_q      <= '0;
      stamp_q      <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      valid_q      <= valid_d;
      dirty_q      <= dirty_d;
      count_q      <= count_d;
      stamp_q      <= stamp_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    trk_q       <= trk_d;
    sec_q       <= sec_d;
    slot_q      <= slot_d;
    opt_q       <= opt_d;
    cnt_q       <= cnt_d;
    pend_idx_q  <= pend_idx_d;
    best_idx_q  <= best_idx_d;
    best_tag_q  <= best_tag_d;
    best_rank_q <= best_rank_d;
    free_idx_q  <= free_idx_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  `SCTT_ASSERT(a_count_matches_valid, clk_i, rst_ni, 32'(count_q) == $countones(valid_q), "valid count disagrees with valid bits")
  `SCTT_ASSERT(a_no_port_clash, clk_i, rst_ni, (st_we && st_re) |-> (st_waddr != st_raddr), "entry memory read and written at one address")
  `SCTT_ASSERT(a_best_is_valid, clk_i, rst_ni, (state_q == sctt_pkg::ST_DECIDE && found_q) |-> valid_q[best_idx_q], "scan picked an invalid entry")
  `SCTT_ASSERT_NEXT(a_transfer_starts, clk_i, rst_ni, req_i.valid && req_i.ready, state_q == sctt_pkg::ST_DISPATCH && !out_valid_q || state_q == sctt_pkg::ST_DISPATCH, "command transfer did not start the sequencer")
endmodule

// ===== sv/sctt_store.sv =====
// Entry memory of the tag table: one write port and one registered read port.
module sctt_store #(
  parameter int unsigned ENTRIES = sctt_pkg::DefEntries
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr_i,
  input  sctt_pkg::tag_t                         wtag_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wrank_i,
  input  logic                                   re_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr_i,
  output sctt_pkg::tag_t                         rtag_o,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rrank_o
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  sctt_pkg::tag_t  mem_tag_q  [ENTRIES];
  logic [IW-1:0]   mem_rank_q [ENTRIES];
  sctt_pkg::tag_t  rtag_q;
  logic [IW-1:0]   rrank_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_tag_q[waddr_i]  <= wtag_i;
      mem_rank_q[waddr_i] <= wrank_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rtag_q  <= mem_tag_q[raddr_i];
      rrank_q <= mem_rank_q[raddr_i];
    end
  end

  assign rtag_o  = rtag_q;
  assign rrank_o = rrank_q;
endmodule

// ===== sv/sctt_cmp.sv =====
// Shared scan comparator: decides whether the entry under test beats the best so far.
module sctt_cmp #(
  parameter int unsigned RankW = 4
) (
  input  logic [2:0]       mode_i,
  input  logic             opt_i,
  input  logic [7:0]       key_track_i,
  input  logic [7:0]       key_sector_i,
  input  logic             cand_valid_i,
  input  logic             cand_dirty_i,
  input  sctt_pkg::tag_t   cand_tag_i,
  input  logic [RankW-1:0] cand_rank_i,
  input  logic             best_found_i,
  input  sctt_pkg::tag_t   best_tag_i,
  input  logic [RankW-1:0] best_rank_i,
  output logic             better_o
);
  logic        rank_lt;
  logic        stamp_lt;
  logic        stamp_eq;
  logic [15:0] cand_key;
  logic [15:0] best_key;
  logic        key_lt;
  logic        key_eq;
  logic        eligible;
  logic        prefer;

  assign rank_lt  = cand_rank_i < best_rank_i;
  assign stamp_lt = cand_tag_i.stamp < best_tag_i.stamp;
  assign stamp_eq = cand_tag_i.stamp == best_tag_i.stamp;
  assign cand_key = {cand_tag_i.track, cand_tag_i.sector};
  assign best_key = {best_tag_i.track, best_tag_i.sector};
  assign key_lt   = cand_key < best_key;
  assign key_eq   = cand_key == best_key;

  always_comb begin
    eligible = 1'b0;
    prefer   = 1'b0;
    unique case (mode_i) inside
      sctt_pkg::CMD_FIND, sctt_pkg::CMD_OBTAIN: begin
        eligible = cand_valid_i && (cand_tag_i.track == key_track_i) &&
                   (cand_tag_i.sector == key_sector_i);
        prefer   = rank_lt;
      end
      sctt_pkg::CMD_REPLACE: begin
        eligible = cand_valid_i && !cand_dirty_i;
        prefer   = stamp_lt || (stamp_eq && rank_lt);
      end
      sctt_pkg::CMD_LOWEST: begin
        eligible = cand_valid_i && (!opt_i || cand_dirty_i);
        prefer   = key_lt || (key_eq && rank_lt);
      end
      default: begin
        eligible = 1'b0;
        prefer   = 1'b0;
      end
    endcase
  end

  // A lower rank means a more recent insertion, which wins every tie.
  assign better_o = eligible && (!best_found_i || prefer);
endmodule

// ===== sim/sector_cache_tag_table_core_test.sv =====
// Testbench for the sector cache tag table core: directed and random commands checked against a predictor.
module sector_cache_tag_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sctt_pkg::*;

  localparam int unsigned Entries   = DefEntries;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldOff   = 300;
  localparam int unsigned TailWait  = 60;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;

  sctt_chan_if #(.payload_t(req_t)) req_ch ();
  sctt_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  sector_cache_tag_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Predicted directory contents.
  logic              dir_valid  [Entries];
  logic              dir_dirty  [Entries];
  logic [7:0]        dir_track  [Entries];
  logic [7:0]        dir_sector [Entries];
  logic [StampW-1:0] dir_stamp  [Entries];
  int unsigned       dir_rank   [Entries];
  logic [StampW-1:0] next_stamp;
  int unsigned       live_count;

  rsp_t awaited_replies[$];
  int   failures;
  bit   sender_steady;
  bit   sink_steady;
  int   hold_request;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rsp_t report(outcome_e oc, int idx);
    rsp_t r;
    r = '0;
    r.outcome = oc;
    if (idx >= 0) begin
      r.result_slot   = idx[SlotW-1:0];
      r.result_track  = dir_track[idx];
      r.result_sector = dir_sector[idx];
      r.result_dirty  = dir_dirty[idx];
    end
    r.entry_count = live_count[CountW-1:0];
    return r;
  endfunction

  // The most recently inserted entry wins when several carry the same tag.
  function automatic int match_tag(logic [7:0] trk, logic [7:0] sec);
    int best;
    best = -1;
    for (int i = 0; i < Entries; i++) begin
      if (dir_valid[i] && dir_track[i] == trk && dir_sector[i] == sec &&
          (best < 0 || dir_rank[i] < dir_rank[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic rsp_t apply_command(req_t c);
    int best;
    logic [15:0] key_i, key_b;
    best = -1;
    case (c.command)
      CMD_FIND: begin
        best = match_tag(c.track, c.sector);
        if (best < 0) return report(OUT_NONE, -1);
        return report(OUT_FOUND, best);
      end
      CMD_OBTAIN: begin
        best = match_tag(c.track, c.sector);
        if (best >= 0) return report(OUT_FOUND, best);
        if (!c.option_bit) return report(OUT_NONE, -1);
        for (int i = 0; i < Entries; i++) begin
          if (!dir_valid[i] && best < 0) best = i;
        end
        if (best < 0) return report(OUT_NONE, -1);
        for (int i = 0; i < Entries; i++) begin
          if (dir_valid[i]) dir_rank[i]++;
        end
        dir_valid[best]  = 1'b1;
        dir_dirty[best]  = 1'b0;
        dir_track[best]  = c.track;
        dir_sector[best] = c.sector;
        dir_stamp[best]  = next_stamp;
        next_stamp       = next_stamp + 1;
        dir_rank[best]   = 0;
        live_count++;
        return report(OUT_TAKEN, best);
      end
      CMD_REPLACE: begin
        for (int i = 0; i < Entries; i++) begin
          if (dir_valid[i] && !dir_dirty[i]) begin
            if (best < 0 || dir_stamp[i] < dir_stamp[best] ||
                (dir_stamp[i] == dir_stamp[best] && dir_rank[i] < dir_rank[best]))
              best = i;
          end
        end
        if (best < 0) return report(OUT_NONE, -1);
        dir_track[best]  = c.track;
        dir_sector[best] = c.sector;
        dir_dirty[best]  = 1'b0;
        dir_stamp[best]  = next_stamp;
        next_stamp       = next_stamp + 1;
        return report(OUT_TAKEN, best);
      end
      CMD_RELEASE: begin
        if (c.slot >= Entries || !dir_valid[c.slot]) return report(OUT_NONE, -1);
        if (c.option_bit) dir_dirty[c.slot] = 1'b1;
        return report(OUT_DONE, int'(c.slot));
      end
      CMD_FREE: begin
        if (c.slot >= Entries || !dir_valid[c.slot]) return report(OUT_NONE, -1);
        dir_valid[c.slot] = 1'b0;
        for (int i = 0; i < Entries; i++) begin
          if (dir_valid[i] && dir_rank[i] > dir_rank[c.slot]) dir_rank[i]--;
        end
        live_count--;
        return report(OUT_DONE, int'(c.slot));
      end
      CMD_LOWEST: begin
        for (int i = 0; i < Entries; i++) begin
          if (dir_valid[i] && !(c.option_bit && !dir_dirty[i])) begin
            if (best < 0) begin
              best = i;
            end else begin
              key_i = {dir_track[i], dir_sector[i]};
              key_b = {dir_track[best], dir_sector[best]};
              if (key_i < key_b || (key_i == key_b && dir_rank[i] < dir_rank[best]))
                best = i;
            end
          end
        end
        if (best < 0) return report(OUT_NONE, -1);
        return report(OUT_FOUND, best);
      end
      CMD_FLUSH: begin
        for (int i = 0; i < Entries; i++) begin
          dir_valid[i] = 1'b0;
          dir_dirty[i] = 1'b0;
        end
        live_count = 0;
        return report(OUT_DONE, -1);
      end
      default: return report(OUT_NONE, -1);
    endcase
  endfunction

  function automatic req_t make_cmd(logic [2:0] cmd, logic [7:0] trk, logic [7:0] sec,
                                    logic [SlotW-1:0] slot, logic opt);
    req_t c;
    c.command    = cmd;
    c.track      = trk;
    c.sector     = sec;
    c.slot       = slot;
    c.option_bit = opt;
    return c;
  endfunction

  // Mostly aims release and free at live entries so that they do real work.
  function automatic logic [SlotW-1:0] pick_slot();
    int live[$];
    for (int i = 0; i < Entries; i++) begin
      if (dir_valid[i]) live.push_back(i);
    end
    if (live.size() > 0 && $urandom_range(0, 99) < 80)
      return SlotW'(live[$urandom_range(0, live.size() - 1)]);
    return SlotW'($urandom_range(0, Entries - 1));
  endfunction

  function automatic req_t random_command();
    req_t c;
    int r;
    r = $urandom_range(0, 99);
    c.option_bit = 1'($urandom_range(0, 1));
    if (r < 30) begin
      c.command = CMD_OBTAIN;
      c.option_bit = 1'b1;
    end else if (r < 33) c.command = CMD_OBTAIN;
    else if (r < 48) c.command = CMD_FIND;
    else if (r < 58) c.command = CMD_REPLACE;
    else if (r < 73) c.command = CMD_RELEASE;
    else if (r < 85) c.command = CMD_FREE;
    else if (r < 95) c.command = CMD_LOWEST;
    else if (r < 97) c.command = CMD_FLUSH;
    else c.command = CMD_UNUSED;
    // A small tag pool makes hits and duplicate tags common.
    if ($urandom_range(0, 99) < 60) begin
      c.track  = 8'($urandom_range(0, 5));
      c.sector = 8'($urandom_range(0, 3));
    end else begin
      c.track  = 8'($urandom_range(0, 255));
      c.sector = 8'($urandom_range(0, 255));
    end
    c.slot = pick_slot();
    return c;
  endfunction

  task automatic send_command(req_t item);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk_i); while (!req_ch.ready);
    awaited_replies.push_back(apply_command(item));
  endtask

  // Lowers valid right after the last transfer and waits for every result.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    wait (awaited_replies.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_command(make_cmd(CMD_FIND, 8'd10, 8'd20, 4'd0, 1'b0));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b0));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_RELEASE, 8'd0, 8'd0, 4'd3, 1'b1));
    send_command(make_cmd(CMD_FREE, 8'd0, 8'd0, 4'd15, 1'b0));
    send_command(make_cmd(CMD_OBTAIN, 8'd0, 8'd0, 4'd0, 1'b0));
    send_command(make_cmd(CMD_OBTAIN, 8'd0, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_OBTAIN, 8'd255, 8'd255, 4'd15, 1'b1));
    send_command(make_cmd(CMD_OBTAIN, 8'd255, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_OBTAIN, 8'd0, 8'd255, 4'd0, 1'b1));
    send_command(make_cmd(CMD_OBTAIN, 8'd255, 8'd255, 4'd0, 1'b1));
    send_command(make_cmd(CMD_FIND, 8'd255, 8'd0, 4'd0, 1'b0));
    send_command(make_cmd(CMD_RELEASE, 8'd0, 8'd0, 4'd1, 1'b1));
    // A release without the dirty flag never cleans an entry.
    send_command(make_cmd(CMD_RELEASE, 8'd0, 8'd0, 4'd1, 1'b0));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b0));
    // Retagging the oldest clean entry to an existing tag creates a duplicate.
    send_command(make_cmd(CMD_REPLACE, 8'd0, 8'd255, 4'd0, 1'b0));
    send_command(make_cmd(CMD_FIND, 8'd0, 8'd255, 4'd0, 1'b0));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b0));
    send_command(make_cmd(CMD_FREE, 8'd0, 8'd0, 4'd2, 1'b0));
    send_command(make_cmd(CMD_OBTAIN, 8'd128, 8'd1, 4'd0, 1'b1));
    send_command(make_cmd(CMD_UNUSED, 8'd255, 8'd255, 4'd15, 1'b1));
    send_command(make_cmd(CMD_FLUSH, 8'd0, 8'd0, 4'd0, 1'b0));
    send_command(make_cmd(CMD_RELEASE, 8'd0, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_REPLACE, 8'd7, 8'd7, 4'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i <= Entries; i++)
      send_command(make_cmd(CMD_OBTAIN, 8'(i * 15), 8'(255 - i), 4'd0, 1'b1));
    send_command(make_cmd(CMD_OBTAIN, 8'd15, 8'd254, 4'd0, 1'b1));
    send_command(make_cmd(CMD_REPLACE, 8'd99, 8'd98, 4'd0, 1'b0));
    for (int i = 0; i < Entries; i++)
      send_command(make_cmd(CMD_RELEASE, 8'd0, 8'd0, 4'(i), 1'b1));
    // With every entry dirty there is nothing to replace.
    send_command(make_cmd(CMD_REPLACE, 8'd1, 8'd1, 4'd0, 1'b0));
    send_command(make_cmd(CMD_LOWEST, 8'd0, 8'd0, 4'd0, 1'b1));
    send_command(make_cmd(CMD_FREE, 8'd0, 8'd0, 4'd15, 1'b0));
    send_command(make_cmd(CMD_OBTAIN, 8'd200, 8'd100, 4'd0, 1'b1));
    send_command(make_cmd(CMD_FLUSH, 8'd0, 8'd0, 4'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    hold_request  = HoldOff;
    sender_steady = 1'b1;
    for (int i = 0; i < 10; i++) send_command(random_command());
    sender_steady = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_steady_stream();
    sender_steady = 1'b1;
    sink_steady   = 1'b1;
    for (int i = 0; i < 40; i++) send_command(random_command());
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 540; i++) begin
      send_command(random_command());
      if (i % 180 == 179) wait_for_drain();
    end
    wait_for_drain();
  endtask

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("result transfer with no command outstanding");
        failures++;
      end else begin
        exp = awaited_replies.pop_front();
        check_field("outcome", 32'(exp.outcome), 32'(rsp_ch.data.outcome));
        check_field("result_slot", 32'(exp.result_slot), 32'(rsp_ch.data.result_slot));
        check_field("result_track", 32'(exp.result_track), 32'(rsp_ch.data.result_track));
        check_field("result_sector", 32'(exp.result_sector),
                    32'(rsp_ch.data.result_sector));
        check_field("result_dirty", 32'(exp.result_dirty), 32'(rsp_ch.data.result_dirty));
        check_field("entry_count", 32'(exp.entry_count), 32'(rsp_ch.data.entry_count));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !sink_steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    failures      = 0;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    hold_request  = 0;
    next_stamp    = '0;
    live_count    = 0;
    for (int i = 0; i < Entries; i++) begin
      dir_valid[i]  = 1'b0;
      dir_dirty[i]  = 1'b0;
      dir_track[i]  = '0;
      dir_sector[i] = '0;
      dir_stamp[i]  = '0;
      dir_rank[i]   = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_backpressure();
    test_steady_stream();
    test_random_traffic();

    repeat (TailWait) @(posedge clk_i);
    if (failures == 0 && awaited_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sctt_pkg.sv
sv/sctt_chan_if.sv
sv/sctt_store.sv
sv/sctt_cmp.sv
sv/sector_cache_tag_table_core.sv
sim/sector_cache_tag_table_core_test.sv
